[rtl/b64u_pkg.sv]
// b64u_pkg: request descriptor type, result kind codes and alphabet mapping
// functions for the base64url codec. No dependencies.
package b64u_pkg;

    // kind of output run that one request produces
    localparam logic [1:0] KIND_CHARS = 2'd0;  // top sextets as alphabet characters
    localparam logic [1:0] KIND_BYTES = 2'd1;  // top bytes of the value
    localparam logic [1:0] KIND_EMPTY = 2'd2;  // one empty end marker

    // one run of results, built by the front end, played out by the back end
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] value;     // data left-aligned at bit 23
        logic [1:0]  last_idx;  // number of results minus one
        logic        eom;
        logic        stop;
    } b64u_job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] sextet;
    } b64u_sextet_t;

    // character for a sextet
    function automatic logic [7:0] b64u_char(input logic [5:0] s);
        logic [7:0] c;
        c = {2'b00, s};
        if (s < 6'd26)
            c = 8'd65 + c;
        else if (s < 6'd52)
            c = 8'd71 + c;          // 'a' - 26
        else if (s < 6'd62)
            c = c - 8'd4;           // '0' - 52
        else if (s == 6'd62)
            c = 8'd45;              // '-'
        else
            c = 8'd95;              // '_'
        return c;
    endfunction

    // sextet for a character; valid low outside the alphabet (incl. 128 and up)
    function automatic b64u_sextet_t b64u_sextet(input logic [7:0] c);
        b64u_sextet_t r;
        r.valid  = 1'b1;
        r.sextet = 6'd0;
        if (c >= 8'd65 && c <= 8'd90)
            r.sextet = 6'(c - 8'd65);
        else if (c >= 8'd97 && c <= 8'd122)
            r.sextet = 6'(c - 8'd71);
        else if (c >= 8'd48 && c <= 8'd57)
            r.sextet = 6'(c + 8'd4);
        else if (c == 8'd45)
            r.sextet = 6'd62;
        else if (c == 8'd95)
            r.sextet = 6'd63;
        else
            r.valid = 1'b0;
        return r;
    endfunction

endpackage

[rtl/b64u_front.sv]
// b64u_front: takes one input byte, updates the group state and issues a
// result-run request. Depends on b64u_pkg.
module b64u_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               direction,
    output logic               job_valid,
    output b64u_pkg::b64u_job_t job
);
    import b64u_pkg::*;

    logic [17:0] bits_reg, bits_next;
    logic [1:0]  count_reg, count_next;
    logic        halted_reg, halted_next;

    b64u_sextet_t sx;
    logic [17:0]  enc_shift, dec_shift, src_bits;
    logic [1:0]   src_count;
    logic         has_data, do_flush;

    assign sx        = b64u_sextet(in_byte);
    assign enc_shift = {bits_reg[9:0], in_byte};
    assign dec_shift = {bits_reg[11:0], sx.sextet};

    always_comb
    begin
        bits_next   = bits_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        has_data    = 1'b0;
        job.kind     = KIND_EMPTY;
        job.value    = 24'd0;
        job.last_idx = 2'd0;
        job.eom      = in_last;
        job.stop     = 1'b0;
        src_bits  = bits_reg;
        src_count = count_reg;
        do_flush  = 1'b0;

        if (!direction)
        begin
            job.kind = KIND_CHARS;
            if (count_reg >= 2'd2)
            begin
                has_data     = 1'b1;
                job.value    = {bits_reg[15:0], in_byte};
                job.last_idx = 2'd3;
                bits_next    = 18'd0;
                count_next   = 2'd0;
            end
            else
            begin
                bits_next  = enc_shift;
                count_next = count_reg + 2'd1;
                if (in_last)
                begin
                    has_data = 1'b1;
                    if (count_reg == 2'd0)
                    begin
                        job.value    = {in_byte, 16'd0};
                        job.last_idx = 2'd1;
                    end
                    else
                    begin
                        job.value    = {enc_shift[15:0], 8'd0};
                        job.last_idx = 2'd2;
                    end
                end
            end
        end
        else
        begin
            job.kind = KIND_BYTES;
            job.stop = halted_reg || !sx.valid;
            if (!halted_reg && sx.valid && count_reg == 2'd3)
            begin
                has_data     = 1'b1;
                job.value    = {bits_reg, sx.sextet};
                job.last_idx = 2'd2;
                bits_next    = 18'd0;
                count_next   = 2'd0;
            end
            else
            begin
                if (!halted_reg && sx.valid)
                begin
                    src_bits  = dec_shift;
                    src_count = count_reg + 2'd1;
                end
                do_flush = in_last || (!halted_reg && !sx.valid);
                if (!halted_reg && !sx.valid)
                    halted_next = 1'b1;
                bits_next  = do_flush ? 18'd0 : src_bits;
                count_next = do_flush ? 2'd0 : src_count;
                // k pending sextets give k-1 bytes
                if (do_flush && src_count >= 2'd2)
                begin
                    has_data     = 1'b1;
                    job.last_idx = src_count - 2'd2;
                    job.value    = (src_count == 2'd2) ? {src_bits[11:0], 12'd0}
                                                       : {src_bits, 6'd0};
                end
            end
        end

        if (!has_data)
        begin
            job.kind     = KIND_EMPTY;
            job.value    = 24'd0;
            job.last_idx = 2'd0;
        end

        if (in_last)
        begin
            bits_next   = 18'd0;
            count_next  = 2'd0;
            halted_next = 1'b0;
        end
    end

    assign job_valid = take && (has_data || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg   <= 18'd0;
            count_reg  <= 2'd0;
            halted_reg <= 1'b0;
        end
        else if (take)
        begin
            bits_reg   <= bits_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

endmodule

[rtl/b64u_queue.sv]
// b64u_queue: small flop-based request queue between front and back end.
// Depends on b64u_pkg.
module b64u_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  b64u_pkg::b64u_job_t wr_job,
    output logic                full,
    input  logic                rd_en,
    output b64u_pkg::b64u_job_t rd_job,
    output logic                empty
);
    import b64u_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    b64u_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

[rtl/b64u_back.sv]
// b64u_back: plays out each request into the output register as one result per
// cycle while that register is free or being popped. Depends on b64u_pkg.
module b64u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  b64u_pkg::b64u_job_t job,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_value,
    output logic                has_data,
    output logic                end_of_message,
    output logic                last_of_run,
    output logic                stopped_early
);
    import b64u_pkg::*;

    b64u_job_t  cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] value_reg;
    logic       has_data_reg, eom_reg, last_reg, stop_reg;

    logic       out_free, advance, done, load;
    logic [5:0] sextet;
    logic [7:0] byte_sel, value_sel;
    logic       is_last;

    assign out_free = !out_valid_reg || pop;
    assign advance  = cur_valid_reg && out_free;
    assign is_last  = (idx_reg == cur_reg.last_idx);
    assign done     = advance && is_last;
    assign load     = !job_empty && (!cur_valid_reg || done);
    assign job_pop  = load;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = cur_reg.value[23:18];
            2'd1:    sextet = cur_reg.value[17:12];
            2'd2:    sextet = cur_reg.value[11:6];
            default: sextet = cur_reg.value[5:0];
        endcase
        unique case (idx_reg)
            2'd0:    byte_sel = cur_reg.value[23:16];
            2'd1:    byte_sel = cur_reg.value[15:8];
            default: byte_sel = cur_reg.value[7:0];
        endcase
        unique case (cur_reg.kind)
            KIND_CHARS: value_sel = b64u_char(sextet);
            KIND_BYTES: value_sel = byte_sel;
            default:    value_sel = 8'd0;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_next       = job;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (done)
            cur_valid_next = 1'b0;
        else if (advance)
            idx_next = idx_reg + 2'd1;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            value_reg    <= value_sel;
            has_data_reg <= (cur_reg.kind != KIND_EMPTY);
            last_reg     <= is_last;
            eom_reg      <= is_last && cur_reg.eom;
            stop_reg     <= cur_reg.stop;
        end
    end

    assign empty          = !out_valid_reg;
    assign out_value      = value_reg;
    assign has_data       = has_data_reg;
    assign end_of_message = eom_reg;
    assign last_of_run    = last_reg;
    assign stopped_early  = stop_reg;

endmodule

[rtl/base64url_codec.sv]
// base64url_codec: unpadded base64url encoder/decoder, one byte per request.
// Depends on b64u_pkg, b64u_front, b64u_queue, b64u_back.
//
//  channel   handshake                 payload
//  -------   ------------------------  ---------------------------------------
//  input     push / full               in_byte, in_last
//  result    pop / empty               out_value, has_data, end_of_message,
//                                      last_of_run, stopped_early
//  config    cfg_valid / cfg_ready     cfg_data (direction: 0 encode, 1 decode)
//
// An input request is taken every cycle while the run queue has room; each
// request turns into a run of 0 to 4 results, and the back end delivers one
// result per cycle while the result side keeps popping, so the back end's single
// output path sets the rate.
// Reset clears the group state, the run queue and the output register.
// A stalled result side fills the queue and then raises full; the input side
// never stalls the back end.
module base64url_codec #(
    parameter int QUEUE_DEPTH = 2   // run queue entries, 2 or more
) (
    input  logic       clk,
    input  logic       rst_n,
    // input requests
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    // results
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_value,
    output logic       has_data,
    output logic       end_of_message,
    output logic       last_of_run,
    output logic       stopped_early,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import b64u_pkg::*;

    logic      direction_reg;
    logic      take;
    logic      fe_job_valid;
    b64u_job_t fe_job;
    logic      q_full, q_empty, q_pop;
    b64u_job_t q_job;

    // the user must write direction only while idle; the block does not enforce it, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            direction_reg <= cfg_data;
    end

    assign full = q_full;
    assign take = push && !q_full;

    // front end: grouping state and run building
    b64u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .direction (direction_reg),
        .job_valid (fe_job_valid),
        .job       (fe_job)
    );

    // decouples run building from result play-out
    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fe_job_valid),
        .wr_job (fe_job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    // back end: one result per cycle into the output register while it is free or popped
    b64u_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_empty      (q_empty),
        .job            (q_job),
        .job_pop        (q_pop),
        .pop            (pop),
        .empty          (empty),
        .out_value      (out_value),
        .has_data       (has_data),
        .end_of_message (end_of_message),
        .last_of_run    (last_of_run),
        .stopped_early  (stopped_early)
    );

endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for base64url_codec (encode and decode, unpadded).
// Depends only on the RTL under rtl/; the expected results come from a
// behavioural model of the codec held in this file.
module tb_top;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;
    localparam int   NO_SEXTET  = 64;

    typedef struct packed {
        logic [7:0] value;
        logic       has_data;
        logic       eom;
        logic       run_end;
        logic       stop;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } request_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       pop = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_data = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_value;
    logic       has_data;
    logic       end_of_message;
    logic       last_of_run;
    logic       stopped_early;
    logic       cfg_ready;

    base64url_codec u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .pop            (pop),
        .empty          (empty),
        .out_value      (out_value),
        .has_data       (has_data),
        .end_of_message (end_of_message),
        .last_of_run    (last_of_run),
        .stopped_early  (stopped_early),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model state: direction plus the pending group
    string       b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    logic        codec_dir = DIR_ENCODE;
    logic [17:0] grp_bits = '0;
    logic [1:0]  grp_cnt = '0;
    logic        grp_halt = 1'b0;

    result_t  run_buf[$];
    result_t  expected_results[$];
    request_t pending_requests[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_taken = 1'b0;
    int  mismatch_count = 0;
    int  requests_taken = 0;
    int  messages_taken = 0;
    int  results_checked = 0;
    int  stopped_messages = 0;
    request_t next_req;
    result_t  got;
    result_t  want;

    // alphabet position of a character, NO_SEXTET if outside the alphabet
    function automatic int char_to_sextet(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
            if (b64_alphabet[i] == c)
                return i;
        return NO_SEXTET;
    endfunction

    function automatic logic [7:0] non_alphabet_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (char_to_sextet(c) != NO_SEXTET)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic emit(input logic [7:0] v, input logic h);
        result_t r;
        r = '0;
        r.value = v;
        r.has_data = h;
        run_buf.push_back(r);
    endtask

    // top cnt sextets of a 24-bit word, as characters
    task automatic emit_chars(input logic [23:0] v, input int cnt);
        logic [23:0] t;
        for (int k = 0; k < cnt; k++)
        begin
            t = v >> (18 - 6 * k);
            emit(b64_alphabet[t[5:0]], 1'b1);
        end
    endtask

    // top cnt bytes of a 24-bit word
    task automatic emit_bytes(input logic [23:0] v, input int cnt);
        logic [23:0] t;
        for (int k = 0; k < cnt; k++)
        begin
            t = v >> (16 - 8 * k);
            emit(t[7:0], 1'b1);
        end
    endtask

    // partial decode group: k sextets give k-1 bytes
    task automatic flush_sextets();
        if (grp_cnt != 0)
            emit_bytes(24'(grp_bits) << (6 * (4 - grp_cnt)), grp_cnt - 1);
        grp_bits = '0;
        grp_cnt  = '0;
    endtask

    task automatic predict_codec_request(input logic [7:0] b, input logic is_last);
        int      s;
        logic    stop_flag;
        result_t r;
        stop_flag = 1'b0;
        run_buf.delete();
        if (codec_dir == DIR_ENCODE)
        begin
            // a third byte (or a leftover third sextet) completes the group
            if (grp_cnt >= 2)
            begin
                emit_chars({grp_bits[15:0], b}, 4);
                grp_bits = '0;
                grp_cnt  = '0;
            end
            else
            begin
                grp_bits = {grp_bits[9:0], b};
                grp_cnt++;
            end
            if (is_last && grp_cnt != 0)
                emit_chars(24'(grp_bits) << (8 * (3 - grp_cnt)), grp_cnt + 1);
        end
        else
        begin
            if (!grp_halt)
            begin
                s = char_to_sextet(b);
                if (s == NO_SEXTET)
                begin
                    grp_halt = 1'b1;
                    flush_sextets();
                end
                else if (grp_cnt == 3)
                begin
                    emit_bytes({grp_bits, 6'(s)}, 3);
                    grp_bits = '0;
                    grp_cnt  = '0;
                end
                else
                begin
                    grp_bits = {grp_bits[11:0], 6'(s)};
                    grp_cnt++;
                end
            end
            if (is_last)
                flush_sextets();
            stop_flag = grp_halt;
        end
        // end of message always yields something, an empty marker if need be
        if (is_last && run_buf.size() == 0)
            emit(8'h00, 1'b0);
        for (int k = 0; k < run_buf.size(); k++)
        begin
            r = run_buf[k];
            r.stop = stop_flag;
            if (k == run_buf.size() - 1)
            begin
                r.run_end = 1'b1;
                r.eom = is_last;
            end
            expected_results.push_back(r);
        end
        if (is_last)
        begin
            grp_bits = '0;
            grp_cnt  = '0;
            grp_halt = 1'b0;
        end
    endtask

    // drive side: requests from the pending queue, pop at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || in_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    push    <= 1'b1;
                    in_byte <= next_req.data;
                    in_last <= next_req.is_last;
                end
                else
                    push <= 1'b0;
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // sample side: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                in_taken = 1'b1;
                requests_taken++;
                if (in_last)
                    messages_taken++;
                predict_codec_request(in_byte, in_last);
            end
            if (pop && !empty)
            begin
                got = {out_value, has_data, end_of_message, last_of_run, stopped_early};
                results_checked++;
                if (end_of_message && stopped_early)
                    stopped_messages++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: value %02h data %b eom %b run_end %b stop %b",
                                 got.value, got.has_data, got.eom, got.run_end, got.stop);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value || got.has_data !== want.has_data ||
                        got.eom !== want.eom || got.run_end !== want.run_end ||
                        got.stop !== want.stop)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected value %02h data %b eom %b run_end %b ",
                                     want.value, want.has_data, want.eom, want.run_end,
                                     "stop %b, got value %02h data %b eom %b run_end %b stop %b",
                                     want.stop, got.value, got.has_data, got.eom,
                                     got.run_end, got.stop);
                    end
                end
            end
        end
    end

    task automatic add_request(input logic [7:0] d, input logic is_last);
        request_t q;
        q.data = d;
        q.is_last = is_last;
        pending_requests.push_back(q);
    endtask

    // random traffic; each request ends its message with probability 1/8, the last one surely if close_msg
    task automatic add_random(input logic dir, input int count, input bit close_msg);
        logic [7:0] d;
        logic       l;
        for (int i = 0; i < count; i++)
        begin
            if (dir == DIR_ENCODE)
                d = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 39) == 0)
                d = non_alphabet_char();
            else
                d = b64_alphabet[$urandom_range(0, 63)];
            l = ($urandom_range(0, 7) == 0) || (close_msg && i == count - 1);
            add_request(d, l);
        end
    endtask

    // hold off until every request is taken and every result is back
    task automatic wait_idle();
        @(posedge clk);
        while (pending_requests.size() != 0 || push || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_direction(input logic d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        codec_dir = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 85;

        // encode: one-byte and two-byte tails, then a full group
        write_direction(DIR_ENCODE);
        add_request(8'h00, 1'b1);
        add_request(8'hff, 1'b0);
        add_request(8'h80, 1'b1);
        add_request("M", 1'b0);
        add_request("a", 1'b0);
        add_request("n", 1'b1);
        wait_idle();

        // decode: full group, lone sextet (empty end), bad chars at two depths
        write_direction(DIR_DECODE);
        add_request("T", 1'b0);
        add_request("W", 1'b0);
        add_request("F", 1'b0);
        add_request("u", 1'b1);
        add_request("A", 1'b1);
        add_request("Q", 1'b0);
        add_request("@", 1'b0);
        add_request("B", 1'b0);
        add_request(8'hff, 1'b1);
        add_request("-", 1'b0);
        add_request("_", 1'b0);
        add_request("0", 1'b0);
        add_request(8'h80, 1'b1);
        wait_idle();

        // direction flipped mid-message: three sextets finished by an encode byte
        add_request("z", 1'b0);
        add_request("9", 1'b0);
        add_request("9", 1'b0);
        wait_idle();
        write_direction(DIR_ENCODE);
        add_request(8'ha5, 1'b1);
        wait_idle();
        // halted decode, then encoding ignores the halt
        write_direction(DIR_DECODE);
        add_request("$", 1'b0);
        wait_idle();
        write_direction(DIR_ENCODE);
        add_request(8'h3c, 1'b1);
        wait_idle();

        // random, slow receiver
        add_random(DIR_ENCODE, 65, 1'b1);
        wait_idle();
        write_direction(DIR_DECODE);
        add_random(DIR_DECODE, 65, 1'b1);
        wait_idle();

        // random, slow sender
        send_idle_pct = 85;
        recv_idle_pct = 14;
        add_random(DIR_DECODE, 65, 1'b1);
        wait_idle();
        write_direction(DIR_ENCODE);
        add_random(DIR_ENCODE, 65, 1'b1);
        wait_idle();

        // full rate, with pauses and direction changes inside open messages
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(DIR_ENCODE, 30, 1'b0);
        wait_idle();
        add_random(DIR_ENCODE, 30, 1'b0);
        wait_idle();
        write_direction(DIR_DECODE);
        add_random(DIR_DECODE, 40, 1'b0);
        wait_idle();
        write_direction(DIR_ENCODE);
        add_random(DIR_ENCODE, 20, 1'b1);
        wait_idle();
        repeat (16) @(posedge clk);

        mismatch_count += expected_results.size();
        $display("Covered %0d requests in %0d messages, %0d results checked",
                 requests_taken, messages_taken, results_checked);
        $display("%0d messages ended with decoding stopped early, %0d mismatches",
                 stopped_messages, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #1600000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
